@@ rtl/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants of the console line editor
// Ring geometry, key codes, echo kinds, index helpers and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cle_pkg;

    // ring geometry: indices count modulo twice the depth
    localparam int BUF_DEPTH = 128;
    localparam int IDX_MOD   = 2 * BUF_DEPTH;
    localparam int IDX_W     = $clog2(BUF_DEPTH) + 1;
    localparam int SLOT_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [SLOT_W-1:0] slot_t;

    localparam idx_t DEPTH_IDX = idx_t'(BUF_DEPTH);
    localparam idx_t DEPTH_M1  = idx_t'(BUF_DEPTH - 1);
    localparam idx_t IDX_LAST  = idx_t'(IDX_MOD - 1);

    // key codes
    localparam logic [7:0] KEY_NUL    = 8'h00;
    localparam logic [7:0] KEY_CTRL_D = 8'h04;
    localparam logic [7:0] KEY_CTRL_H = 8'h08;
    localparam logic [7:0] KEY_LF     = 8'h0a;
    localparam logic [7:0] KEY_CR     = 8'h0d;
    localparam logic [7:0] KEY_CTRL_P = 8'h10;
    localparam logic [7:0] KEY_CTRL_U = 8'h15;
    localparam logic [7:0] KEY_DEL    = 8'h7f;

    // echo kinds
    localparam logic [1:0] ECHO_NONE  = 2'd0;
    localparam logic [1:0] ECHO_CHAR  = 2'd1;
    localparam logic [1:0] ECHO_ERASE = 2'd2;

    // request modes
    localparam logic MODE_RX   = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // result of one request
    typedef struct packed {
        logic [1:0] echo_kind;
        logic [7:0] echo_char;
        logic [7:0] erase_count;
        logic       dump_request;
        logic       line_committed;
        logic       read_valid;
        logic [7:0] read_char;
        logic       read_eof;
        logic       read_line_end;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pop_issue;
        logic pop_finish;
        logic dump;
        logic erase;
        logic store;
        logic kill_issue;
        logic kill_step;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic is_dump;
        logic is_kill;
        logic is_erase;
        logic is_store;
        logic can_pop;
        logic has_edit;
        logic has_room;
        logic kill_lf;
        logic kill_last;
    } sts_t;

    // index helpers
    function automatic idx_t idx_inc(idx_t i);
        return (i == IDX_LAST) ? '0 : i + idx_t'(1);
    endfunction

    function automatic idx_t idx_dec(idx_t i);
        return (i == '0) ? IDX_LAST : i - idx_t'(1);
    endfunction

    function automatic slot_t idx_slot(idx_t i);
        idx_t t;
        t = (i >= DEPTH_IDX) ? i - DEPTH_IDX : i;
        return t[SLOT_W-1:0];
    endfunction

    function automatic idx_t idx_dist(idx_t hi, idx_t lo);
        logic [IDX_W:0] t;
        t = (hi >= lo) ? {1'b0, hi} - {1'b0, lo}
                       : {1'b0, hi} + (IDX_W+1)'(IDX_MOD) - {1'b0, lo};
        return t[IDX_W-1:0];
    endfunction

endpackage

@@ rtl/cle_ctrl.sv @@
// ----------------------------------------------------------------------------
// cle_ctrl: sequencing controller of the console line editor
// Takes one request at a time, steps the datapath through pop, edit or
// kill-line walk, then hands the result to the output register.
// ----------------------------------------------------------------------------
module cle_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          out_free,
    input  cle_pkg::sts_t sts,
    output cle_pkg::cmd_t cmd
);
    import cle_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE       = 6'b000001,
        S_EXEC       = 6'b000010,
        S_POP_WAIT   = 6'b000100,
        S_KILL_ISSUE = 6'b001000,
        S_KILL_WAIT  = 6'b010000,
        S_DONE       = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                if (sts.is_read) begin
                    if (sts.can_pop) begin
                        cmd.pop_issue = 1'b1;
                        state_next    = S_POP_WAIT;
                    end
                end else if (sts.is_dump) begin
                    cmd.dump = 1'b1;
                end else if (sts.is_kill) begin
                    if (sts.has_edit) begin
                        state_next = S_KILL_ISSUE;
                    end
                end else if (sts.is_erase) begin
                    cmd.erase = sts.has_edit;
                end else if (sts.is_store) begin
                    cmd.store = sts.has_room;
                end
            end
            S_POP_WAIT: begin
                cmd.pop_finish = 1'b1;
                state_next     = S_DONE;
            end
            S_KILL_ISSUE: begin
                cmd.kill_issue = 1'b1;
                state_next     = S_KILL_WAIT;
            end
            S_KILL_WAIT: begin
                if (sts.kill_lf) begin
                    state_next = S_DONE;
                end else begin
                    cmd.kill_step = 1'b1;
                    state_next    = sts.kill_last ? S_DONE : S_KILL_ISSUE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // a request is only taken while nothing is in flight
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> (state_reg == S_IDLE))
        else $error("ready raised outside idle");

    // a kill step always comes in the cycle after its store read
    a_kill_after_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.kill_step |-> $past(cmd.kill_issue))
        else $error("kill step without a store read");

    // a pop finishes right after its read was issued
    a_pop_after_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop_issue |=> cmd.pop_finish)
        else $error("pop read not finished");

endmodule

@@ rtl/cle_datapath.sv @@
// ----------------------------------------------------------------------------
// cle_datapath: line store, ring indices and result assembly
// Holds the request, the byte ring memory, the read, commit and edit
// indices, the kill counter and the result fields of the current request.
// ----------------------------------------------------------------------------
module cle_datapath (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_mode,
    input  logic [7:0]    in_char,
    input  logic          in_first,
    input  cle_pkg::cmd_t cmd,
    output cle_pkg::sts_t sts,
    output cle_pkg::res_t res
);
    import cle_pkg::*;

    // captured request
    logic       mode_reg;
    logic [7:0] char_reg;
    logic       first_reg;

    // ring indices and kill counter
    idx_t read_idx_reg, commit_idx_reg, edit_idx_reg;
    idx_t cnt_reg;

    // result fields
    logic [1:0] kind_reg;
    logic [7:0] echo_reg;
    logic       dump_reg;
    logic       commit_flag_reg;
    logic       rvalid_reg;
    logic [7:0] rchar_reg;
    logic       eof_reg;
    logic       lend_reg;

    // line store
    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] q_reg;
    slot_t      raddr;
    logic       re;

    logic [7:0] store_char;
    idx_t       edit_dec;
    idx_t       edit_inc;
    idx_t       used;

    assign store_char = (char_reg == KEY_CR) ? KEY_LF : char_reg;
    assign edit_dec   = idx_dec(edit_idx_reg);
    assign edit_inc   = idx_inc(edit_idx_reg);
    assign used       = idx_dist(edit_idx_reg, read_idx_reg);
    assign re         = cmd.pop_issue | cmd.kill_issue;
    assign raddr      = cmd.kill_issue ? idx_slot(edit_dec) : idx_slot(read_idx_reg);

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            mem[idx_slot(edit_idx_reg)] <= store_char;
        end
        if (re) begin
            q_reg <= mem[raddr];
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= in_mode;
            char_reg  <= in_char;
            first_reg <= in_first;
        end
    end

    // indices
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_idx_reg   <= '0;
            commit_idx_reg <= '0;
            edit_idx_reg   <= '0;
        end else begin
            if (cmd.pop_finish && !(q_reg == KEY_CTRL_D && !first_reg)) begin
                read_idx_reg <= idx_inc(read_idx_reg);
            end
            if (cmd.erase || cmd.kill_step) begin
                edit_idx_reg <= edit_dec;
            end else if (cmd.store) begin
                edit_idx_reg <= edit_inc;
                if (store_char == KEY_LF || store_char == KEY_CTRL_D
                        || used == DEPTH_M1) begin
                    commit_idx_reg <= edit_inc;
                end
            end
        end
    end

    // result fields and kill counter
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg        <= ECHO_NONE;
            echo_reg        <= '0;
            dump_reg        <= 1'b0;
            commit_flag_reg <= 1'b0;
            rvalid_reg      <= 1'b0;
            rchar_reg       <= '0;
            eof_reg         <= 1'b0;
            lend_reg        <= 1'b0;
            cnt_reg         <= '0;
        end else begin
            if (cmd.dump) begin
                dump_reg <= 1'b1;
            end
            if (cmd.erase) begin
                kind_reg <= ECHO_ERASE;
                cnt_reg  <= idx_t'(1);
            end
            if (cmd.kill_step) begin
                kind_reg <= ECHO_ERASE;
                cnt_reg  <= cnt_reg + idx_t'(1);
            end
            if (cmd.store) begin
                kind_reg        <= ECHO_CHAR;
                echo_reg        <= store_char;
                commit_flag_reg <= (store_char == KEY_LF || store_char == KEY_CTRL_D
                                    || used == DEPTH_M1);
            end
            if (cmd.pop_finish) begin
                rvalid_reg <= 1'b1;
                rchar_reg  <= q_reg;
                eof_reg    <= (q_reg == KEY_CTRL_D);
                lend_reg   <= (q_reg == KEY_LF);
            end
        end
    end

    // saturated erase count
    logic [IDX_W+8:0] cnt_wide;
    logic [7:0]       cnt_sat;
    assign cnt_wide = (IDX_W+9)'(cnt_reg);
    assign cnt_sat  = (cnt_wide > (IDX_W+9)'(255)) ? 8'hff : cnt_wide[7:0];

    // status to controller
    always_comb begin
        sts           = '0;
        sts.is_read   = (mode_reg == MODE_READ);
        if (mode_reg == MODE_RX) begin
            unique case (char_reg)
                KEY_CTRL_P:          sts.is_dump  = 1'b1;
                KEY_CTRL_U:          sts.is_kill  = 1'b1;
                KEY_CTRL_H, KEY_DEL: sts.is_erase = 1'b1;
                KEY_NUL:             sts.is_store = 1'b0;
                default:             sts.is_store = 1'b1;
            endcase
        end
        sts.can_pop   = (read_idx_reg != commit_idx_reg);
        sts.has_edit  = (edit_idx_reg != commit_idx_reg);
        sts.has_room  = (used < DEPTH_IDX);
        sts.kill_lf   = (q_reg == KEY_LF);
        sts.kill_last = (edit_dec == commit_idx_reg);
    end

    // result out
    always_comb begin
        res                = '0;
        res.echo_kind      = kind_reg;
        res.echo_char      = echo_reg;
        res.erase_count    = (kind_reg == ECHO_ERASE) ? cnt_sat : 8'h00;
        res.dump_request   = dump_reg;
        res.line_committed = commit_flag_reg;
        res.read_valid     = rvalid_reg;
        res.read_char      = rchar_reg;
        res.read_eof       = eof_reg;
        res.read_line_end  = lend_reg;
    end

    // unread data never exceeds the ring
    a_ring_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_dist(edit_idx_reg, read_idx_reg) <= DEPTH_IDX)
        else $error("ring overfilled");

    // commit point lies between read and edit points
    a_commit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_dist(commit_idx_reg, read_idx_reg) <= idx_dist(edit_idx_reg, read_idx_reg))
        else $error("commit index outside read..edit");

    // each kill step erases exactly one byte
    a_kill_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.kill_step |=> (cnt_reg == $past(cnt_reg) + idx_t'(1)))
        else $error("kill count did not advance");

endmodule

@@ rtl/console_line_editor_unit.sv @@
// ----------------------------------------------------------------------------
// console_line_editor_unit: canonical-mode console line buffer
// Top level: request/result stream ports, output register, controller
// and datapath.
// ----------------------------------------------------------------------------
// Usage
//   s_* carries requests: s_tuser is the mode (0 received key, 1 read of one
//   byte), s_tdata holds the key and the first-of-read flag. m_* returns one
//   result per request: m_tuser is the echo kind, m_tdata the echo, erase,
//   commit and read fields.
//   One request is worked on at a time. After the accepting edge, a key's
//   result is formed in the execute state and then moves into the output
//   register; a read that finds data passes a pop-wait state first. A
//   kill-line walks the store from the edit point back, one memory read plus
//   one compare per erased byte; it erases up to one less than the buffer depth.
//   A new request is taken as soon as the previous one has moved into the
//   output register, even while that result waits for m_tready; a stalled
//   receiver holds that result, lets one more request finish its work and
//   then blocks the input.
//   Reset clears the read, commit and edit indices and empties the output
//   register; the store contents need no clearing.
// ----------------------------------------------------------------------------
module console_line_editor_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_char, [8] first_of_read, rest zero
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] echo_char, [15:8] erase_count,
                                   // [16] dump_request, [17] line_committed,
                                   // [18] read_valid, [26:19] read_char,
                                   // [27] read_eof, [28] read_line_end
    output logic [1:0]  m_tuser    // [1:0] echo_kind
);
    import cle_pkg::*;

    cmd_t cmd;
    sts_t sts;
    res_t res;

    logic out_free;
    logic m_tvalid_reg;
    res_t out_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    cle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    cle_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_mode  (s_tuser),
        .in_char  (s_tdata[7:0]),
        .in_first (s_tdata[8]),
        .cmd      (cmd),
        .sts      (sts),
        .res      (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= res;
        end
    end

    // result packing
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.echo_kind;
    assign m_tdata  = {3'b000, out_reg.read_line_end, out_reg.read_eof,
                       out_reg.read_char, out_reg.read_valid, out_reg.line_committed,
                       out_reg.dump_request, out_reg.erase_count, out_reg.echo_char};

    // the output register is only loaded when it is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result overwritten");

    // a loaded result is presented in the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result not presented");

    // no request is taken in the cycle a result is loaded
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !s_tready)
        else $error("request accepted during result load");

endmodule

@@ tb/console_line_editor_unit_test.sv @@
// ----------------------------------------------------------------------------
// console_line_editor_unit_test: self-checking bench of the console line editor
// Drives key and read requests into the stream input and mirrors the line
// discipline (ring, read/commit/edit positions) in an internal model. Each
// result is compared field by field with the oldest predicted reply. Both
// sides stall at random, with two long receiver holds and sender drain pauses.
// ----------------------------------------------------------------------------
module console_line_editor_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cle_pkg::*;

    localparam int unsigned ITEM_TARGET = 1900;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned PRINT_CAP   = 100;

    // one request as queued for the driver
    typedef struct packed {
        logic       mode;
        logic [7:0] key;
        logic       first;
        logic       drain;
    } tty_req_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [7:0] rx_char, [8] first_of_read, rest zero
    logic        s_tuser  = 1'b0; // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [7:0] echo_char, [15:8] erase_count,
                                  // [16] dump_request, [17] line_committed,
                                  // [18] read_valid, [26:19] read_char,
                                  // [27] read_eof, [28] read_line_end
    logic [1:0]  m_tuser;         // [1:0] echo_kind

    console_line_editor_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // request stream and predicted replies
    tty_req_t    tty_requests[$];
    res_t        tty_replies[$];
    tty_req_t    cur_req;
    logic        drain_next = 1'b0;
    int unsigned req_total = 0;
    int unsigned reqs_accepted = 0;
    int unsigned replies_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned send_gap = 0;
    int unsigned send_burst = 0;
    int unsigned ready_wait = 0;
    int unsigned recv_burst = 0;

    // mirrored line discipline state
    logic [7:0]  ring_bytes[BUF_DEPTH];
    int unsigned rd_pos = 0;
    int unsigned commit_pos = 0;
    int unsigned edit_pos = 0;

    initial begin
        for (int i = 0; i < BUF_DEPTH; i++) ring_bytes[i] = 8'h00;
    end

    function automatic int unsigned pos_fwd(int unsigned p);
        return (p + 1) % IDX_MOD;
    endfunction

    function automatic int unsigned pos_back(int unsigned p);
        return (p + IDX_MOD - 1) % IDX_MOD;
    endfunction

    // unread bytes between read position and p
    function automatic int unsigned unread_upto(int unsigned p);
        return (p + IDX_MOD - rd_pos) % IDX_MOD;
    endfunction

    // apply one request to the mirrored line state, return its reply
    function automatic res_t tty_discipline(tty_req_t rq);
        res_t        r;
        int unsigned n;
        logic [7:0]  c;
        r = '0;
        n = 0;
        if (rq.mode == MODE_READ) begin
            if (rd_pos != commit_pos) begin
                c = ring_bytes[rd_pos % BUF_DEPTH];
                r.read_valid = 1'b1;
                r.read_char  = c;
                if (c == KEY_CTRL_D) begin
                    // end-of-file stays put unless it opens the read call
                    r.read_eof = 1'b1;
                    if (rq.first) rd_pos = pos_fwd(rd_pos);
                end else begin
                    rd_pos = pos_fwd(rd_pos);
                    r.read_line_end = (c == KEY_LF);
                end
            end
        end else if (rq.key == KEY_CTRL_P) begin
            r.dump_request = 1'b1;
        end else if (rq.key == KEY_CTRL_U) begin
            // kill back to commit point or newline
            while (edit_pos != commit_pos &&
                   ring_bytes[pos_back(edit_pos) % BUF_DEPTH] != KEY_LF) begin
                edit_pos = pos_back(edit_pos);
                n++;
            end
            if (n != 0) begin
                r.echo_kind   = ECHO_ERASE;
                r.erase_count = (n > 255) ? 8'd255 : 8'(n);
            end
        end else if (rq.key == KEY_CTRL_H || rq.key == KEY_DEL) begin
            if (edit_pos != commit_pos) begin
                edit_pos      = pos_back(edit_pos);
                r.echo_kind   = ECHO_ERASE;
                r.erase_count = 8'd1;
            end
        end else if (rq.key != KEY_NUL && unread_upto(edit_pos) < BUF_DEPTH) begin
            c = (rq.key == KEY_CR) ? KEY_LF : rq.key;
            r.echo_kind = ECHO_CHAR;
            r.echo_char = c;
            ring_bytes[edit_pos % BUF_DEPTH] = c;
            edit_pos = pos_fwd(edit_pos);
            // newline, end-of-file or a full ring makes the line readable
            if (c == KEY_LF || c == KEY_CTRL_D || unread_upto(edit_pos) == BUF_DEPTH) begin
                commit_pos       = edit_pos;
                r.line_committed = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic add_req(logic mode, logic [7:0] key, logic first);
        tty_req_t rq;
        rq.mode  = mode;
        rq.key   = key;
        rq.first = first;
        rq.drain = drain_next;
        drain_next = 1'b0;
        tty_requests.push_back(rq);
        req_total++;
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    // one edited line with a random ending
    task automatic type_line(int unsigned len);
        int unsigned pick;
        logic [7:0]  k;
        for (int unsigned i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6)       k = ($urandom_range(0, 1) != 0) ? KEY_CTRL_H : KEY_DEL;
            else if (pick < 8)  k = KEY_CTRL_P;
            else if (pick < 9)  k = KEY_NUL;
            else if (pick < 10) k = KEY_CTRL_U;
            else if (pick < 20) k = 8'($urandom_range(0, 255));
            else                k = printable();
            add_req(MODE_RX, k, 1'($urandom_range(0, 1)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 35)      add_req(MODE_RX, KEY_LF, 1'($urandom_range(0, 1)));
        else if (pick < 60) add_req(MODE_RX, KEY_CR, 1'($urandom_range(0, 1)));
        else if (pick < 70) add_req(MODE_RX, KEY_CTRL_D, 1'($urandom_range(0, 1)));
        else if (pick < 85) add_req(MODE_RX, KEY_CTRL_U, 1'($urandom_range(0, 1)));
    endtask

    // one read call: first pop flagged, the rest not
    task automatic read_call(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            add_req(MODE_READ, 8'($urandom_range(0, 255)), i == 0);
    endtask

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            if (mismatches < PRINT_CAP)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, fname, want, got);
            mismatches++;
        end
    endtask

    // compare one result with the oldest predicted reply
    task automatic check_reply();
        res_t want;
        if (tty_replies.size() == 0) begin
            if (mismatches < PRINT_CAP)
                $display("%0t: unexpected result, expected none, actual tuser 0x%0h tdata 0x%0h",
                         $time, m_tuser, m_tdata);
            mismatches++;
        end else begin
            want = tty_replies.pop_front();
            check_field("echo_kind", want.echo_kind, m_tuser);
            check_field("echo_char", want.echo_char, m_tdata[7:0]);
            check_field("erase_count", want.erase_count, m_tdata[15:8]);
            check_field("dump_request", want.dump_request, m_tdata[16]);
            check_field("line_committed", want.line_committed, m_tdata[17]);
            check_field("read_valid", want.read_valid, m_tdata[18]);
            check_field("read_char", want.read_char, m_tdata[26:19]);
            check_field("read_eof", want.read_eof, m_tdata[27]);
            check_field("read_line_end", want.read_line_end, m_tdata[28]);
        end
    endtask

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                tty_replies.push_back(tty_discipline(cur_req));
                reqs_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (tty_requests.size() != 0 &&
                             !(tty_requests[0].drain && tty_replies.size() != 0)) begin
                    cur_req = tty_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_req.mode;
                    s_tdata  <= {7'b0, cur_req.first, cur_req.key};
                    // idle before the next request, with bursts of none
                    if (send_burst != 0) begin
                        send_burst--;
                        send_gap = 0;
                    end else begin
                        send_gap = $urandom_range(0, 6);
                        if ($urandom_range(0, 39) == 0) send_burst = $urandom_range(10, 60);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_wait = 0;
        end else if (m_tvalid && m_tready) begin
            check_reply();
            replies_seen++;
            if (recv_burst != 0) begin
                recv_burst--;
                ready_wait = 0;
            end else begin
                ready_wait = $urandom_range(0, 6);
                if ($urandom_range(0, 39) == 0) recv_burst = $urandom_range(10, 60);
            end
            // long hold so the block backs up into its input
            if (replies_seen == 150 || replies_seen == 900) ready_wait = LONG_HOLD;
            m_tready <= (ready_wait == 0);
        end else if (ready_wait != 0) begin
            ready_wait--;
            m_tready <= (ready_wait == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("console_line_editor_unit_test failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned pick;

        // directed: empty read, ignored and control keys on an empty line
        add_req(MODE_READ, 8'h00, 1'b1);
        add_req(MODE_RX, KEY_NUL, 1'b0);
        add_req(MODE_RX, KEY_CTRL_P, 1'b1);
        add_req(MODE_RX, KEY_CTRL_H, 1'b0);
        add_req(MODE_RX, KEY_CTRL_U, 1'b0);
        add_req(MODE_RX, KEY_DEL, 1'b0);
        // byte extremes, erase and kill
        add_req(MODE_RX, 8'h61, 1'b0);
        add_req(MODE_RX, 8'hff, 1'b1);
        add_req(MODE_RX, 8'h80, 1'b0);
        add_req(MODE_RX, KEY_DEL, 1'b0);
        add_req(MODE_RX, 8'h62, 1'b0);
        add_req(MODE_RX, KEY_CTRL_U, 1'b1);
        // carriage return maps to newline, end-of-file commits
        add_req(MODE_RX, 8'h78, 1'b0);
        add_req(MODE_RX, KEY_CR, 1'b0);
        add_req(MODE_RX, KEY_CTRL_D, 1'b0);
        // reads: newline, end-of-file kept mid-call, consumed at call start
        add_req(MODE_READ, 8'hff, 1'b1);
        add_req(MODE_READ, 8'h00, 1'b0);
        add_req(MODE_READ, 8'h00, 1'b0);
        add_req(MODE_READ, 8'h00, 1'b1);
        add_req(MODE_READ, 8'h00, 1'b0);
        // backspace right after a commit does nothing
        add_req(MODE_RX, 8'h71, 1'b0);
        add_req(MODE_RX, KEY_LF, 1'b0);
        add_req(MODE_RX, KEY_CTRL_H, 1'b0);
        add_req(MODE_READ, 8'h00, 1'b1);
        add_req(MODE_READ, 8'h00, 1'b0);

        // fill the ring to force a full commit and dropped bytes, then drain
        drain_next = 1'b1;
        repeat (135) add_req(MODE_RX, printable(), 1'($urandom_range(0, 1)));
        read_call(140);
        // longest kill of an uncommitted line
        repeat (127) add_req(MODE_RX, printable(), 1'b0);
        add_req(MODE_RX, KEY_CTRL_U, 1'b0);

        // random sessions: lines, read calls and noise
        while (tty_requests.size() < ITEM_TARGET) begin
            if ($urandom_range(0, 99) == 0) drain_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                type_line(($urandom_range(0, 9) == 0) ? $urandom_range(100, 140)
                                                       : $urandom_range(0, 20));
            else if (pick < 85)
                read_call(($urandom_range(0, 7) == 0) ? $urandom_range(40, 140)
                                                       : $urandom_range(1, 20));
            else
                repeat ($urandom_range(1, 8))
                    add_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
        end

        // reset
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (reqs_accepted != req_total) @(posedge aclk);
        while (tty_replies.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        if (mismatches == 0)
            $display("console_line_editor_unit_test passed");
        else
            $display("console_line_editor_unit_test failed");
        $finish;
    end

endmodule
